// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker of the search FIFO.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on i_clk, off while the reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Assertion that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- design/cfws_pkg.sv -----
// ----------------------------------------------------------------------------
// cfws_pkg
// Constants, types and helpers of the circular FIFO with search.
// ----------------------------------------------------------------------------
package cfws_pkg;

    localparam int DEPTH  = 128;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 8;

    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_DEQ = 2'd1;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_OVERFLOW  = 3'd1,
        STAT_REMOVED   = 3'd2,
        STAT_UNDERFLOW = 3'd3,
        STAT_FOUND     = 3'd4,
        STAT_NOT_FOUND = 3'd5,
        STAT_EMPTY     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ_RD,
        S_SEARCH,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    enq;
        logic    deq;
        logic    load_head;
        logic    search_start;
        logic    search_step;
        logic    set_status;
        t_status status;
        logic    emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic is_enq;
        logic is_deq;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

// ----- design/circular_fifo_with_search.sv -----
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Circular-buffer FIFO of signed 32-bit words with enqueue, dequeue and search.
// ----------------------------------------------------------------------------
// Each input word carries a kind (enqueue, dequeue or search, where the unused
// code acts as a search) and a value, and gives exactly one result word with
// a status, the dequeued value (zero otherwise), the occupancy after the
// operation and the head word with its valid flag. The block works on one
// operation at a time. An enqueue, or any operation that fails on a full or
// empty queue, passes through the execute and result states; a dequeue also
// passes through a read state, as the new head word must come back from the
// single read port of the storage RAM. A search walks the RAM one entry per
// cycle from head to tail, with the compare in the cycle after the read, and
// stops early on the first match. The result sits in an output register, so
// a new operation is accepted while the previous result still waits to be
// taken.
// ----------------------------------------------------------------------------
module circular_fifo_with_search import cfws_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input channel.
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic signed [WORD_W-1:0] i_value,
    // Result channel.
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_status,
    output logic signed [WORD_W-1:0] o_removed_value,
    output logic [OCC_W-1:0]         o_occupancy,
    output logic signed [WORD_W-1:0] o_head_value,
    output logic                     o_head_valid
);

    // Command and status between the sequencer and the datapath.
    t_cmd  w_cmd;
    t_stat w_stat;

    // The sequencer owns the input handshake and decides, for each operation,
    // which datapath actions run and in which order.
    cfws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the pointers, the fill count, a copy of the head
    // word, the storage RAM and the output register of the result channel.
    cfws_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_out_stall     (i_out_stall),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy),
        .o_head_value    (o_head_value),
        .o_head_valid    (o_head_valid)
    );

endmodule

// ----- design/cfws_ram.sv -----
// ----------------------------------------------------------------------------
// cfws_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cfws_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfws_ctrl
// Sequencer of the search FIFO: decodes each operation and steps the datapath.
// ----------------------------------------------------------------------------
module cfws_ctrl import cfws_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.set_status = 1'b1;
                if (i_stat.is_enq) begin
                    if (i_stat.full) begin
                        o_cmd.status = STAT_OVERFLOW;
                    end else begin
                        o_cmd.status = STAT_INSERTED;
                        o_cmd.enq    = 1'b1;
                    end
                    n_state = S_RESULT;
                end else if (i_stat.is_deq) begin
                    if (i_stat.empty) begin
                        o_cmd.status = STAT_UNDERFLOW;
                        n_state      = S_RESULT;
                    end else begin
                        o_cmd.status = STAT_REMOVED;
                        o_cmd.deq    = 1'b1;
                        n_state      = S_DEQ_RD;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.status = STAT_EMPTY;
                        n_state      = S_RESULT;
                    end else begin
                        o_cmd.status       = STAT_NOT_FOUND;
                        o_cmd.search_start = 1'b1;
                        n_state            = S_SEARCH;
                    end
                end
            end
            S_DEQ_RD: begin
                o_cmd.load_head = 1'b1;
                n_state         = S_RESULT;
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = STAT_FOUND;
                    n_state          = S_RESULT;
                end else if (i_stat.last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/cfws_dp.sv -----
// ----------------------------------------------------------------------------
// cfws_dp
// Datapath of the search FIFO: pointers, fill count, storage and result word.
// ----------------------------------------------------------------------------
module cfws_dp import cfws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_kind,
    input  logic [WORD_W-1:0] i_value,
    input  logic              i_out_stall,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [2:0]        o_status,
    output logic [WORD_W-1:0] o_removed_value,
    output logic [OCC_W-1:0]  o_occupancy,
    output logic [WORD_W-1:0] o_head_value,
    output logic              o_head_valid
);

    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [WORD_W-1:0] r_head_value;
    logic [1:0]        r_kind;
    logic [WORD_W-1:0] r_value;
    logic [WORD_W-1:0] r_removed;
    t_status           r_status;

    logic [PTR_W-1:0]  r_sptr;
    logic [CNT_W-1:0]  r_issue;
    logic [CNT_W-1:0]  r_cmp_cnt;
    logic              r_cmp_vld;

    logic              r_out_valid;
    logic [2:0]        r_out_status;
    logic [WORD_W-1:0] r_out_removed;
    logic [OCC_W-1:0]  r_out_occ;
    logic [WORD_W-1:0] r_out_head;
    logic              r_out_head_vld;

    logic              w_issue;
    logic              w_re;
    logic [PTR_W-1:0]  w_raddr;
    logic [WORD_W-1:0] w_rdata;
    logic [31:0]       w_count_ext;
    logic              w_nonempty;

    assign w_nonempty  = (r_count != '0);
    assign w_issue     = i_cmd.search_step && (r_issue < r_count);
    assign w_re        = i_cmd.deq || w_issue;
    assign w_raddr     = i_cmd.deq ? next_slot(r_head) : r_sptr;
    assign w_count_ext = 32'(r_count);

    cfws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq),
        .i_waddr (r_tail),
        .i_wdata (r_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Queue state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.enq) begin
                r_tail  <= next_slot(r_tail);
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.deq) begin
                r_head  <= next_slot(r_head);
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Search walk control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.search_start) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= w_issue;
        end
    end

    // Payload registers; these need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= i_kind;
            r_value   <= i_value;
            r_removed <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.enq && !w_nonempty) begin
            r_head_value <= r_value;
        end
        if (i_cmd.deq) begin
            r_removed <= r_head_value;
        end
        if (i_cmd.load_head) begin
            r_head_value <= w_rdata;
        end
        if (i_cmd.search_start) begin
            r_sptr    <= r_head;
            r_issue   <= '0;
            r_cmp_cnt <= '0;
        end else begin
            if (w_issue) begin
                r_sptr  <= next_slot(r_sptr);
                r_issue <= r_issue + CNT_W'(1);
            end
            if (i_cmd.search_step && r_cmp_vld) begin
                r_cmp_cnt <= r_cmp_cnt + CNT_W'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status   <= r_status;
            r_out_removed  <= r_removed;
            r_out_occ      <= w_count_ext[OCC_W-1:0];
            r_out_head     <= w_nonempty ? r_head_value : '0;
            r_out_head_vld <= w_nonempty;
        end
    end

    assign o_stat.empty    = !w_nonempty;
    assign o_stat.full     = (r_count == CNT_W'(DEPTH));
    assign o_stat.is_enq   = (r_kind == KIND_ENQ);
    assign o_stat.is_deq   = (r_kind == KIND_DEQ);
    assign o_stat.hit      = r_cmp_vld && (w_rdata == r_value);
    assign o_stat.last     = r_cmp_vld && (r_cmp_cnt == (r_count - CNT_W'(1)));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_value = r_out_removed;
    assign o_occupancy     = r_out_occ;
    assign o_head_value    = r_out_head;
    assign o_head_valid    = r_out_head_vld;

endmodule

// ----- design/cfws_checker.sv -----
// ----------------------------------------------------------------------------
// cfws_checker
// Port-level assertions of the search FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfws_checker import cfws_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [2:0]               o_status,
    input logic signed [WORD_W-1:0] o_removed_value,
    input logic [OCC_W-1:0]         o_occupancy,
    input logic signed [WORD_W-1:0] o_head_value,
    input logic                     o_head_valid
);

    logic                                 w_held;
    logic [3+WORD_W+OCC_W+WORD_W+1-1:0]   w_out_word;
    logic                                 w_flag_bad;
    logic                                 w_zero_bad;
    logic                                 w_removed_bad;
    logic                                 w_overflow_bad;

    assign w_held         = o_out_valid && i_out_stall;
    assign w_out_word     = {o_status, o_removed_value, o_occupancy, o_head_value,
                             o_head_valid};
    assign w_flag_bad     = o_out_valid && (o_head_valid != (o_occupancy != 8'd0));
    assign w_zero_bad     = o_out_valid && !o_head_valid && (o_head_value != '0);
    assign w_removed_bad  = o_out_valid && (o_status != STAT_REMOVED)
                            && (o_removed_value != '0);
    assign w_overflow_bad = o_out_valid && (o_status == STAT_OVERFLOW)
                            && (o_occupancy != OCC_W'(DEPTH));

    // A stalled result word holds its valid and its fields.
    `ASSERT_CLK(a_out_hold, w_held |=> o_out_valid && $stable(w_out_word), "stalled result changed")

    // The head flag agrees with the occupancy.
    `ASSERT_NEVER(a_head_flag, w_flag_bad, "head_valid disagrees with occupancy")

    // An empty queue shows a zero head word.
    `ASSERT_NEVER(a_head_zero, w_zero_bad, "head word not zero while empty")

    // Only a dequeue that removed a word reports a removed value.
    `ASSERT_NEVER(a_removed_zero, w_removed_bad, "removed value set without removal")

    // Overflow only on a full queue.
    `ASSERT_NEVER(a_overflow_full, w_overflow_bad, "overflow on a queue that is not full")

endmodule

bind circular_fifo_with_search cfws_checker u_cfws_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circular FIFO with search.
// ----------------------------------------------------------------------------
// A short table of directed words covers underflow, empty search, the unused
// kind code and the extreme values. A phased random run follows, with fill,
// drain, search and mixed phases. The fill phases run the queue into overflow,
// the drain phases run it into underflow, and the pointers wrap along the way.
// A behavioral copy of the queue predicts every result word. The checker
// compares each result field by field against the oldest expectation. Both
// channels idle at random. The result side also holds off for long stretches
// so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module testbench import cfws_pkg::*;;

    // Kind codes that the package does not name. The decoder compares both bits
    // and treats every code but enqueue and dequeue as a search, the spare one too.
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    localparam int RANDOM_WORDS = 800;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] removed_value;
        logic [OCC_W-1:0]         occupancy;
        logic signed [WORD_W-1:0] head_value;
        logic                     head_valid;
    } t_fifo_result;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] value;
        logic                     fixed_want;
        t_fifo_result             want;
    } t_stim_row;

    typedef enum int {PH_FILL, PH_DRAIN, PH_SEARCH, PH_MIXED} t_phase;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_kind;
    logic signed [WORD_W-1:0] i_value;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [2:0]               o_status;
    logic signed [WORD_W-1:0] o_removed_value;
    logic [OCC_W-1:0]         o_occupancy;
    logic signed [WORD_W-1:0] o_head_value;
    logic                     o_head_valid;

    circular_fifo_with_search u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy),
        .o_head_value    (o_head_value),
        .o_head_valid    (o_head_valid)
    );

    // Behavioral copy of the queue, advanced once per accepted input word.
    logic signed [WORD_W-1:0] queue_mem [DEPTH];
    int                       queue_head = 0;
    int                       queue_tail = 0;
    int                       queue_fill = 0;

    t_fifo_result expected_results [$];
    int           error_count    = 0;
    int           words_issued   = 0;
    int           results_taken  = 0;
    bit           send_calm      = 0;
    int           send_calm_left = 0;

    // Directed words. Rows with fixed_want set carry a result that is plain
    // from the queue contents. The other rows are checked against the copy.
    t_stim_row directed_rows [23] = '{
        '{KIND_DEQ,    32'sh0000_0000, 1'b1, '{STAT_UNDERFLOW, 32'sh0, 8'd0, 32'sh0, 1'b0}},
        '{KIND_SEARCH, 32'sh0000_0000, 1'b1, '{STAT_EMPTY, 32'sh0, 8'd0, 32'sh0, 1'b0}},
        '{KIND_SPARE,  32'sh7fff_ffff, 1'b1, '{STAT_EMPTY, 32'sh0, 8'd0, 32'sh0, 1'b0}},
        '{KIND_ENQ,    32'sh8000_0000, 1'b1,
          '{STAT_INSERTED, 32'sh0, 8'd1, 32'sh8000_0000, 1'b1}},
        '{KIND_ENQ,    32'sh7fff_ffff, 1'b1,
          '{STAT_INSERTED, 32'sh0, 8'd2, 32'sh8000_0000, 1'b1}},
        '{KIND_ENQ,    32'shffff_ffff, 1'b0, '0},
        '{KIND_ENQ,    32'sh0000_0000, 1'b0, '0},
        '{KIND_SEARCH, 32'sh8000_0000, 1'b0, '0},
        '{KIND_SEARCH, 32'sh0000_0000, 1'b0, '0},
        '{KIND_SEARCH, 32'sh0000_0001, 1'b0, '0},
        '{KIND_SPARE,  32'shffff_ffff, 1'b0, '0},
        '{KIND_SPARE,  32'shffff_fffe, 1'b0, '0},
        '{KIND_DEQ,    32'sh5a5a_5a5a, 1'b1,
          '{STAT_REMOVED, 32'sh8000_0000, 8'd3, 32'sh7fff_ffff, 1'b1}},
        '{KIND_DEQ,    32'sha5a5_a5a5, 1'b0, '0},
        '{KIND_DEQ,    32'sh0000_0000, 1'b0, '0},
        '{KIND_DEQ,    32'shffff_ffff, 1'b0, '0},
        '{KIND_DEQ,    32'sh0000_0000, 1'b1, '{STAT_UNDERFLOW, 32'sh0, 8'd0, 32'sh0, 1'b0}},
        '{KIND_SEARCH, 32'sh8000_0000, 1'b1, '{STAT_EMPTY, 32'sh0, 8'd0, 32'sh0, 1'b0}},
        '{KIND_ENQ,    32'sh5555_5555, 1'b0, '0},
        '{KIND_ENQ,    32'shaaaa_aaaa, 1'b0, '0},
        '{KIND_SEARCH, 32'shaaaa_aaaa, 1'b0, '0},
        '{KIND_DEQ,    32'sh0000_0000, 1'b0, '0},
        '{KIND_DEQ,    32'sh0000_0000, 1'b0, '0}
    };

    // Applies one operation to the queue copy and returns the result word
    // that the block should give for it.
    function automatic t_fifo_result queue_apply(input logic [1:0] kind,
                                                 input logic signed [WORD_W-1:0] value);
        t_fifo_result res;
        int           slot;
        res = '0;
        if (kind == KIND_ENQ) begin
            if (queue_fill == DEPTH) begin
                res.status = STAT_OVERFLOW;
            end else begin
                queue_mem[queue_tail] = value;
                queue_tail = (queue_tail + 1) % DEPTH;
                queue_fill++;
                res.status = STAT_INSERTED;
            end
        end else if (kind == KIND_DEQ) begin
            if (queue_fill == 0) begin
                res.status = STAT_UNDERFLOW;
            end else begin
                res.removed_value = queue_mem[queue_head];
                queue_head = (queue_head + 1) % DEPTH;
                queue_fill--;
                res.status = STAT_REMOVED;
            end
        end else if (queue_fill == 0) begin
            res.status = STAT_EMPTY;
        end else begin
            // Walk from head to tail and stop on the first match.
            res.status = STAT_NOT_FOUND;
            slot = queue_head;
            for (int i = 0; i < queue_fill; i++) begin
                if (queue_mem[slot] == value) begin
                    res.status = STAT_FOUND;
                    break;
                end
                slot = (slot + 1) % DEPTH;
            end
        end
        res.occupancy  = OCC_W'(queue_fill);
        res.head_valid = (queue_fill != 0);
        res.head_value = (queue_fill != 0) ? queue_mem[queue_head] : '0;
        return res;
    endfunction

    // Mostly full-range words. Some are extremes, and some come from a small
    // pool so that the queue holds duplicates.
    function automatic logic signed [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            1, 2:    return WORD_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // A search key: when the queue holds any word, a stored one half of the time; else random.
    function automatic logic signed [WORD_W-1:0] search_key();
        if (queue_fill != 0 && $urandom_range(0, 1) == 0)
            return queue_mem[(queue_head + $urandom_range(0, queue_fill - 1)) % DEPTH];
        return random_word();
    endfunction

    function automatic logic [1:0] search_kind();
        return ($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_SEARCH;
    endfunction

    // Offers one input word after a random gap and waits until it is taken.
    // The expectation is queued at the edge that accepts the word.
    task automatic issue(input logic [1:0] kind, input logic signed [WORD_W-1:0] value,
                         input logic fixed_want = 1'b0, input t_fifo_result want = '0);
        int           gap;
        t_fifo_result predicted;
        if (send_calm_left == 0) begin
            send_calm      = ($urandom_range(0, 2) == 0);
            send_calm_left = $urandom_range(10, 50);
        end
        send_calm_left--;
        gap = send_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        predicted = queue_apply(kind, value);
        expected_results.push_back(fixed_want ? want : predicted);
        words_issued++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stimulus: reset, the directed table, then the random phases.
    initial begin
        int     span;
        int     random_start;
        t_phase phase;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind     <= KIND_ENQ;
        i_value    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            issue(directed_rows[r].kind, directed_rows[r].value,
                  directed_rows[r].fixed_want, directed_rows[r].want);

        random_start = words_issued;
        while (words_issued - random_start < RANDOM_WORDS) begin
            span = $urandom_range(8, 48);
            case ($urandom_range(0, 6))
                0:       phase = PH_FILL;
                1:       phase = PH_DRAIN;
                2:       phase = PH_SEARCH;
                default: phase = PH_MIXED;
            endcase
            case (phase)
                PH_FILL: begin
                    // Run up to full, then push against the full queue.
                    while (queue_fill < DEPTH)
                        issue(($urandom_range(0, 7) == 0) ? KIND_DEQ : KIND_ENQ,
                              random_word());
                    repeat ($urandom_range(1, 3)) issue(KIND_ENQ, random_word());
                end
                PH_DRAIN: begin
                    while (queue_fill > 0) begin
                        if ($urandom_range(0, 9) == 0)
                            issue(search_kind(), search_key());
                        else
                            issue(KIND_DEQ, random_word());
                    end
                    repeat ($urandom_range(1, 3)) issue(KIND_DEQ, random_word());
                end
                PH_SEARCH: begin
                    repeat (span) issue(search_kind(), search_key());
                end
                default: begin
                    repeat (span) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: issue(KIND_ENQ, random_word());
                            4, 5, 6:    issue(KIND_DEQ, random_word());
                            default:    issue(search_kind(), search_key());
                        endcase
                    end
                end
            endcase
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: a random hold before each word, calm stretches without
    // holds, and two long holds that back the block up into its input.
    initial begin
        int hold;
        int calm_left;
        bit calm;
        calm_left = 0;
        calm      = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(10, 40);
            end
            calm_left--;
            hold = calm ? 0 : $urandom_range(0, 6);
            if (results_taken == 150 || results_taken == 600)
                hold = LONG_HOLD;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            results_taken++;
        end
    end

    // Compares every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_fifo_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: status %0d", o_status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_removed_value !== want.removed_value) begin
                    $error("removed_value: expected %0d, got %0d",
                           want.removed_value, o_removed_value);
                    error_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                    error_count++;
                end
                if (o_head_value !== want.head_value) begin
                    $error("head_value: expected %0d, got %0d",
                           want.head_value, o_head_value);
                    error_count++;
                end
                if (o_head_valid !== want.head_valid) begin
                    $error("head_valid: expected %0d, got %0d",
                           want.head_valid, o_head_valid);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/cfws_pkg.sv
design/cfws_ram.sv
design/cfws_ctrl.sv
design/cfws_dp.sv
design/circular_fifo_with_search.sv
design/cfws_checker.sv
tb/testbench.sv
